// ===== rtl/biq_pkg.sv =====
// shared types and constants for the biquad iir filter unit
// coefficient format, register indexes, sequencer states and the coefficient bundle
// no dependencies
package biq_pkg;

  // coefficient format: signed q2.14
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned COEF_FRAC  = 14;
  // counter over the coefficient bits, one bit per step
  localparam int unsigned COEF_CNT_W = 4;
  // headroom of the internal value over the sample width
  localparam int unsigned DELAY_GUARD = 4;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

  // reset values of the coefficients (b0 = 1.0, all others 0)
  localparam logic [COEF_W-1:0] B0_RESET = 16'h4000;
  localparam logic [COEF_W-1:0] COEF_ZERO = 16'h0000;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } biq_coef_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FEEDBACK,
    ST_UPDATE,
    ST_FEEDFWD,
    ST_RESULT
  } biq_state_e;

endpackage

// ===== rtl/biq_serial_mul.sv =====
// bit-serial shift-and-add multiplier lane for the biquad iir filter unit
// emits one partial product per step, coefficient consumed lsb first
// depends on biq_pkg
module biq_serial_mul #(
  parameter int unsigned DataW = 20,
  parameter int unsigned AccW  = 38
) (
  input  logic                            clk_i,
  input  logic                            load_i,
  input  logic                            step_i,
  input  logic                            neg_i,
  input  logic signed [DataW-1:0]         mcand_i,
  input  logic [biq_pkg::COEF_W-1:0]      coef_i,
  output logic signed [AccW-1:0]          pp_o
);

  logic signed [AccW-1:0]         mcand_q, mcand_d;
  logic [biq_pkg::COEF_W-1:0]     coef_q, coef_d;

  always_comb begin
    mcand_d = mcand_q;
    coef_d  = coef_q;
    if (load_i) begin
      mcand_d = {{(AccW-DataW){mcand_i[DataW-1]}}, mcand_i};
      coef_d  = coef_i;
    end else if (step_i) begin
      mcand_d = mcand_q <<< 1;
      coef_d  = coef_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q <= mcand_d;
    coef_q  <= coef_d;
  end

  // the coefficient sign bit carries negative weight
  assign pp_o = coef_q[0] ? (neg_i ? -mcand_q : mcand_q) : '0;

endmodule

// ===== rtl/biq_core.sv =====
// sequencer and datapath of the biquad iir filter unit
// three serial multiplier lanes feed one accumulator; holds the two delays
// depends on biq_pkg and biq_serial_mul
module biq_core #(
  parameter int unsigned SampleW = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [SampleW-1:0]  sample_i,
  input  biq_pkg::biq_coef_t         coef_i,
  input  logic                       out_free_i,
  output logic                       ready_o,
  output logic                       done_o,
  output logic signed [SampleW-1:0]  y_o
);

  localparam int unsigned DelayW = SampleW + biq_pkg::DELAY_GUARD;
  localparam int unsigned AccW   = DelayW + biq_pkg::COEF_W + 2;
  localparam int unsigned RndW   = AccW - biq_pkg::COEF_FRAC;
  localparam int unsigned DiffW  = RndW + 1;
  localparam logic signed [AccW-1:0] RndHalf =
    {{(AccW-biq_pkg::COEF_FRAC){1'b0}}, 1'b1, {(biq_pkg::COEF_FRAC-1){1'b0}}};
  localparam logic [biq_pkg::COEF_CNT_W-1:0] CntLast =
    biq_pkg::COEF_CNT_W'(biq_pkg::COEF_W - 1);

  biq_pkg::biq_state_e state_q, state_d;
  logic [biq_pkg::COEF_CNT_W-1:0] cnt_q, cnt_d;
  logic signed [AccW-1:0]         acc_q, acc_d;
  logic signed [SampleW-1:0]      x_q;
  logic signed [DelayW-1:0]       d1_q, d2_q;

  logic                           load, step, neg;
  logic signed [DelayW-1:0]       m0, m1, m2;
  logic [biq_pkg::COEF_W-1:0]     c0, c1, c2;
  logic signed [AccW-1:0]         pp0, pp1, pp2;

  logic signed [AccW-1:0]         rnd_sum;
  logic signed [RndW-1:0]         scaled;
  logic signed [DiffW-1:0]        diff;
  logic signed [DelayW-1:0]       w_sat;
  logic                           w_hi, w_lo, y_hi, y_lo;

  // rounding: add half an lsb, then arithmetic shift by the fraction bits
  assign rnd_sum = acc_q + RndHalf;
  assign scaled  = rnd_sum[AccW-1:biq_pkg::COEF_FRAC];
  assign diff    = {{(DiffW-SampleW){x_q[SampleW-1]}}, x_q} - {scaled[RndW-1], scaled};

  // internal value saturates to the delay width
  assign w_hi  = !diff[DiffW-1] && (|diff[DiffW-2:DelayW-1]);
  assign w_lo  = diff[DiffW-1] && !(&diff[DiffW-2:DelayW-1]);
  assign w_sat = w_hi ? {1'b0, {(DelayW-1){1'b1}}} :
                 w_lo ? {1'b1, {(DelayW-1){1'b0}}} : diff[DelayW-1:0];

  // output saturates to the sample width
  assign y_hi = !scaled[RndW-1] && (|scaled[RndW-2:SampleW-1]);
  assign y_lo = scaled[RndW-1] && !(&scaled[RndW-2:SampleW-1]);
  assign y_o  = y_hi ? {1'b0, {(SampleW-1){1'b1}}} :
                y_lo ? {1'b1, {(SampleW-1){1'b0}}} : scaled[SampleW-1:0];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    load    = 1'b0;
    step    = 1'b0;
    ready_o = 1'b0;
    done_o  = 1'b0;
    // feedback pass: a1*d1 + a2*d2, third lane idle
    m0 = d1_q;
    m1 = d2_q;
    m2 = '0;
    c0 = coef_i.a1;
    c1 = coef_i.a2;
    c2 = biq_pkg::COEF_ZERO;
    case (state_q)
      biq_pkg::ST_IDLE: begin
        ready_o = 1'b1;
        if (start_i) begin
          load    = 1'b1;
          cnt_d   = '0;
          acc_d   = '0;
          state_d = biq_pkg::ST_FEEDBACK;
        end
      end
      biq_pkg::ST_FEEDBACK, biq_pkg::ST_FEEDFWD: begin
        step  = 1'b1;
        acc_d = acc_q + pp0 + pp1 + pp2;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          state_d = (state_q == biq_pkg::ST_FEEDBACK) ? biq_pkg::ST_UPDATE
                                                      : biq_pkg::ST_RESULT;
        end
      end
      biq_pkg::ST_UPDATE: begin
        // feedforward pass: b0*w + b1*d1 + b2*d2 with the old delays
        load    = 1'b1;
        m0      = w_sat;
        m1      = d1_q;
        m2      = d2_q;
        c0      = coef_i.b0;
        c1      = coef_i.b1;
        c2      = coef_i.b2;
        cnt_d   = '0;
        acc_d   = '0;
        state_d = biq_pkg::ST_FEEDFWD;
      end
      biq_pkg::ST_RESULT: begin
        if (out_free_i) begin
          done_o  = 1'b1;
          state_d = biq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = biq_pkg::ST_IDLE;
      end
    endcase
  end

  assign neg = (cnt_q == CntLast);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= biq_pkg::ST_IDLE;
      cnt_q   <= '0;
      d1_q    <= '0;
      d2_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == biq_pkg::ST_UPDATE) begin
        d2_q <= d1_q;
        d1_q <= w_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (ready_o && start_i) begin
      x_q <= sample_i;
    end
  end

  biq_serial_mul #(.DataW(DelayW), .AccW(AccW)) u_lane0 (
    .clk_i  (clk_i),
    .load_i (load),
    .step_i (step),
    .neg_i  (neg),
    .mcand_i(m0),
    .coef_i (c0),
    .pp_o   (pp0)
  );

  biq_serial_mul #(.DataW(DelayW), .AccW(AccW)) u_lane1 (
    .clk_i  (clk_i),
    .load_i (load),
    .step_i (step),
    .neg_i  (neg),
    .mcand_i(m1),
    .coef_i (c1),
    .pp_o   (pp1)
  );

  biq_serial_mul #(.DataW(DelayW), .AccW(AccW)) u_lane2 (
    .clk_i  (clk_i),
    .load_i (load),
    .step_i (step),
    .neg_i  (neg),
    .mcand_i(m2),
    .coef_i (c2),
    .pp_o   (pp2)
  );

endmodule

// ===== rtl/biq_iir_filter_unit_top.sv =====
// second-order iir section (direct form ii), one sample in, one sample out
// top level: stream ports, coefficient registers, output register
// depends on biq_pkg and biq_core
//
// Each accepted input transaction yields exactly one output transaction. The
// section forms w = x - round((a1*d1 + a2*d2) / 2^14), saturated to
// SAMPLE_WIDTH+4 bits, and y = round((b0*w + b1*d1 + b2*d2) / 2^14), saturated
// to SAMPLE_WIDTH bits, with d1 and d2 the delays before this sample; then
// d2 takes d1 and d1 takes w. Rounding is half toward plus infinity.
// Coefficients are signed q2.14 and are written through the cfg port
// (index 0 b0, 1 b1, 2 b2, 3 a1, 4 a2; other indexes are ignored); reset
// gives b0 = 1.0 and all others 0, so the section passes samples through.
// Write coefficients only while no sample is in flight.
// Sequence: the multiplies are bit-serial over the 16 coefficient bits, three
// lanes in parallel; each sample is loaded, then runs the feedback pass, the
// delay update, the feedforward pass and the hand-off, which waits while the
// output side stalls; no new sample is taken before that hand-off. Input is
// taken while the previous result still sits in the output register.
module biquad_iir_filter_unit #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,   // [SAMPLE_WIDTH-1:0] sample_in
  // output stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    m_axis_tdata,   // [SAMPLE_WIDTH-1:0] sample_out
  // coefficient write port
  input  logic                                 cfg_we_i,
  input  logic [biq_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [biq_pkg::COEF_W-1:0]           cfg_data_i
);

  localparam int unsigned TdataW = ((SAMPLE_WIDTH + 7) / 8) * 8;

  biq_pkg::biq_coef_t          coef_q;
  logic                        out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] out_data_q;

  logic                        core_ready, core_done, out_free;
  logic signed [SAMPLE_WIDTH-1:0] core_y;

  // coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.b0 <= biq_pkg::B0_RESET;
      coef_q.b1 <= biq_pkg::COEF_ZERO;
      coef_q.b2 <= biq_pkg::COEF_ZERO;
      coef_q.a1 <= biq_pkg::COEF_ZERO;
      coef_q.a2 <= biq_pkg::COEF_ZERO;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        biq_pkg::REG_B0: coef_q.b0 <= cfg_data_i;
        biq_pkg::REG_B1: coef_q.b1 <= cfg_data_i;
        biq_pkg::REG_B2: coef_q.b2 <= cfg_data_i;
        biq_pkg::REG_A1: coef_q.a1 <= cfg_data_i;
        biq_pkg::REG_A2: coef_q.a2 <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // output register frees up when empty or being drained this cycle
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_done) begin
      out_data_q <= core_y;
    end
  end

  assign s_axis_tready = core_ready;
  assign m_axis_tvalid = out_valid_q;
  // zero fill up to whole bytes
  assign m_axis_tdata  = TdataW'($unsigned(out_data_q));

  biq_core #(.SampleW(SAMPLE_WIDTH)) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (s_axis_tvalid),
    .sample_i  (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .coef_i    (coef_q),
    .out_free_i(out_free),
    .ready_o   (core_ready),
    .done_o    (core_done),
    .y_o       (core_y)
  );

endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for biquad_iir_filter_unit: directed table, then random phases
// each output transaction is checked against an in-bench direct form ii predictor or a typed-in result
// depends on biq_pkg and the rtl of biquad_iir_filter_unit
module tb_top;
  import biq_pkg::*;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned DELAY_W   = SAMPLE_W + DELAY_GUARD;
  localparam int unsigned DATA_W    = ((SAMPLE_W + 7) / 8) * 8;
  // settling wait after the last output before touching the registers
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam int unsigned LONG_HOLD     = 600;
  localparam int unsigned NUM_PHASES    = 10;
  localparam int unsigned PHASE_ITEMS   = 115;
  localparam int unsigned NUM_ROWS      = 32;

  // indexes past the five coefficients, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // q2.14 patterns used by the directed rows and phase settings
  localparam logic [COEF_W-1:0] COEF_MAX  = 16'h7fff;
  localparam logic [COEF_W-1:0] COEF_MIN  = 16'h8000;
  localparam logic [COEF_W-1:0] COEF_HALF = 16'h2000;

  localparam logic [SAMPLE_W-1:0] SMP_MAX  = 16'h7fff;
  localparam logic [SAMPLE_W-1:0] SMP_MIN  = 16'h8000;
  localparam logic [SAMPLE_W-1:0] SMP_ONE  = 16'h0001;
  localparam logic [SAMPLE_W-1:0] SMP_MONE = 16'hffff;
  localparam logic [SAMPLE_W-1:0] SMP_ZERO = 16'h0000;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;     // register index for writes
    logic [COEF_W-1:0]    value;   // coefficient or input sample
    bit                   typed;   // use the typed-in result instead of the predictor
    logic [SAMPLE_W-1:0]  want;
  } stim_row_t;

  // ---------------------------------------------------------------------------
  // clock, reset and dut ports
  // ---------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DATA_W-1:0]    s_axis_tdata  = '0;   // [15:0] sample_in
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [DATA_W-1:0]    m_axis_tdata;         // [15:0] sample_out
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [COEF_W-1:0]    cfg_data_i    = '0;

  always #1 clk_i = ~clk_i;

  biquad_iir_filter_unit #(
    .SAMPLE_WIDTH(SAMPLE_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // predictor: coefficient copy, delay line and the filtered samples still owed
  // ---------------------------------------------------------------------------
  biq_coef_t                 coef_shadow;
  logic signed [DELAY_W-1:0] delay_one;
  logic signed [DELAY_W-1:0] delay_two;
  logic [SAMPLE_W-1:0]       pending_outputs [$];

  int unsigned mismatch_count = 0;
  int unsigned samples_sent   = 0;
  int unsigned outputs_seen   = 0;
  int unsigned settings_used  = 0;

  // signed clamp to a width of bits
  function automatic longint clamp(longint v, int unsigned bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // scale a q2.14 product down, adding half an lsb first (round half up)
  function automatic longint q14_round(longint v);
    return (v + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
  endfunction

  // one direct form ii step, advances the delay line
  function automatic logic [SAMPLE_W-1:0] biquad_step(logic [SAMPLE_W-1:0] x);
    longint xs, d1, d2, fb, w, acc, y;
    xs  = longint'($signed(x));
    d1  = longint'(delay_one);
    d2  = longint'(delay_two);
    fb  = q14_round(longint'(coef_shadow.a1) * d1 + longint'(coef_shadow.a2) * d2);
    w   = clamp(xs - fb, DELAY_W);
    acc = longint'(coef_shadow.b0) * w + longint'(coef_shadow.b1) * d1
        + longint'(coef_shadow.b2) * d2;
    y   = clamp(q14_round(acc), SAMPLE_W);
    delay_two = delay_one;
    delay_one = DELAY_W'(w);
    return SAMPLE_W'(y);
  endfunction

  // ---------------------------------------------------------------------------
  // directed table
  // after reset the section passes samples through; b0 alone then shows
  // output saturation and rounding, the full-scale taps drive the internal
  // value past the sample range
  stim_row_t stim_rows [NUM_ROWS] = '{
    '{ROW_SAMPLE, REG_B0, SMP_ZERO, 1'b1, SMP_ZERO},
    '{ROW_SAMPLE, REG_B0, SMP_MAX,  1'b1, SMP_MAX},
    '{ROW_SAMPLE, REG_B0, SMP_MIN,  1'b1, SMP_MIN},
    '{ROW_SAMPLE, REG_B0, SMP_ONE,  1'b1, SMP_ONE},
    '{ROW_SAMPLE, REG_B0, SMP_MONE, 1'b1, SMP_MONE},
    // b0 near +2: output clips both ways, 1 becomes 2
    '{ROW_WRITE,  REG_B0, COEF_MAX, 1'b0, SMP_ZERO},
    '{ROW_SAMPLE, REG_B0, SMP_MAX,  1'b1, SMP_MAX},
    '{ROW_SAMPLE, REG_B0, SMP_MIN,  1'b1, SMP_MIN},
    '{ROW_SAMPLE, REG_B0, SMP_ONE,  1'b1, 16'h0002},
    // b0 = -2: sign flips and clips, 1 becomes -2 (floor of -1.5)
    '{ROW_WRITE,  REG_B0, COEF_MIN, 1'b0, SMP_ZERO},
    '{ROW_SAMPLE, REG_B0, SMP_MAX,  1'b1, SMP_MIN},
    '{ROW_SAMPLE, REG_B0, SMP_MIN,  1'b1, SMP_MAX},
    '{ROW_SAMPLE, REG_B0, SMP_ONE,  1'b1, 16'hfffe},
    // b0 = 0.5: exact halves round toward plus infinity
    '{ROW_WRITE,  REG_B0, COEF_HALF, 1'b0, SMP_ZERO},
    '{ROW_SAMPLE, REG_B0, SMP_ONE,  1'b1, SMP_ONE},
    '{ROW_SAMPLE, REG_B0, SMP_MONE, 1'b1, SMP_ZERO},
    // full-scale taps but b0 = 1.0, internal value grows past the sample range
    '{ROW_WRITE,  REG_B0, B0_RESET, 1'b0, SMP_ZERO},
    '{ROW_WRITE,  REG_B1, COEF_MAX, 1'b0, SMP_ZERO},
    '{ROW_WRITE,  REG_B2, COEF_MIN, 1'b0, SMP_ZERO},
    '{ROW_WRITE,  REG_A1, COEF_MIN, 1'b0, SMP_ZERO},
    '{ROW_WRITE,  REG_A2, COEF_MAX, 1'b0, SMP_ZERO},
    '{ROW_SAMPLE, REG_B0, SMP_MAX,  1'b0, SMP_ZERO},
    '{ROW_SAMPLE, REG_B0, SMP_MAX,  1'b0, SMP_ZERO},
    '{ROW_SAMPLE, REG_B0, SMP_MIN,  1'b0, SMP_ZERO},
    '{ROW_SAMPLE, REG_B0, SMP_MIN,  1'b0, SMP_ZERO},
    '{ROW_SAMPLE, REG_B0, SMP_MAX,  1'b0, SMP_ZERO},
    // feedback off, then writes to unused indexes that must change nothing
    '{ROW_WRITE,  REG_A1, COEF_ZERO, 1'b0, SMP_ZERO},
    '{ROW_WRITE,  REG_A2, COEF_ZERO, 1'b0, SMP_ZERO},
    '{ROW_WRITE,  REG_SPARE_LO, 16'hffff, 1'b0, SMP_ZERO},
    '{ROW_WRITE,  REG_SPARE_HI, 16'h5a5a, 1'b0, SMP_ZERO},
    '{ROW_SAMPLE, REG_B0, 16'h1234, 1'b0, SMP_ZERO},
    '{ROW_SAMPLE, REG_B0, 16'hedcb, 1'b0, SMP_ZERO}
  };

  // ---------------------------------------------------------------------------
  // sender: bursts of random length separated by random gaps
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  bit          no_gaps    = 1'b0;
  bit          writes_open = 1'b0;

  task automatic send_sample(input logic [SAMPLE_W-1:0] x, input bit typed,
                             input logic [SAMPLE_W-1:0] y_typed);
    int unsigned gap;
    logic [SAMPLE_W-1:0] y_pred;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      // long gaps land on varied steps of a sample's sequence
      if (no_gaps) gap = 0;
      else if ($urandom_range(0, 4) == 0) gap = $urandom_range(5, 45);
      else gap = $urandom_range(0, 3);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= DATA_W'(x);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    // transaction taken at this edge
    burst_left--;
    samples_sent++;
    y_pred = biquad_step(x);
    pending_outputs.push_back(typed ? y_typed : y_pred);
  endtask

  // drop valid and wait until the section has nothing in flight
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // one register write; enable stays high until close_writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      REG_B0:  coef_shadow.b0 = value;
      REG_B1:  coef_shadow.b1 = value;
      REG_B2:  coef_shadow.b2 = value;
      REG_A1:  coef_shadow.a1 = value;
      REG_A2:  coef_shadow.a2 = value;
      default: ;
    endcase
    writes_open = 1'b1;
  endtask

  task automatic close_writes();
    if (writes_open) cfg_we_i <= 1'b0;
    writes_open = 1'b0;
  endtask

  task automatic apply_setting(input biq_coef_t c);
    wait_idle();
    write_reg(REG_B0, c.b0);
    write_reg(REG_B1, c.b1);
    write_reg(REG_B2, c.b2);
    write_reg(REG_A1, c.a1);
    write_reg(REG_A2, c.a2);
    // a stray write to an unused index rides along
    write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
              COEF_W'($urandom_range(0, 65535)));
    close_writes();
    settings_used++;
  endtask

  function automatic logic [COEF_W-1:0] rand_coef();
    return COEF_W'($urandom_range(0, 65535));
  endfunction

  // mild feedback in about -0.5 .. 0.5
  function automatic logic [COEF_W-1:0] rand_small_coef();
    return COEF_W'(int'($urandom_range(0, 16384)) - 8192);
  endfunction

  // mostly full-range and low-level audio, some extremes
  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return SMP_MAX;
          1:       return SMP_MIN;
          2:       return SMP_ONE;
          3:       return SMP_MONE;
          default: return SMP_ZERO;
        endcase
      end
      1, 2, 3, 4, 5: return SAMPLE_W'($urandom_range(0, 65535));
      default:       return SAMPLE_W'(int'($urandom_range(0, 4096)) - 2048);
    endcase
  endfunction

  function automatic biq_coef_t phase_setting(int unsigned phase);
    biq_coef_t c;
    case (phase)
      1: c = '{COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX};
      2: c = '{COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN};
      // gentle low-pass, a1 = -1.5, a2 = 0.6
      3: c = '{16'h0400, 16'h0800, 16'h0400, 16'ha000, 16'h2666};
      4: c = '{rand_coef(), rand_coef(), rand_coef(), rand_small_coef(), rand_small_coef()};
      5: c = '{B0_RESET, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO};
      6: c = '{COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO};
      // resonator right at the edge of stability, a1 = -1.98, a2 = 0.99
      7: c = '{16'h0100, COEF_ZERO, 16'hff00, 16'h8148, 16'h3f5c};
      9: c = '{rand_coef(), rand_coef(), rand_coef(), rand_small_coef(), rand_small_coef()};
      default: c = '{rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef()};
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // receiver: stall pattern redrawn when its random run length runs out, plus a long
  // hold-off on request so the section backs up and drops s_axis_tready
  // ---------------------------------------------------------------------------
  int unsigned hold_off_asks  = 0;
  int unsigned hold_off_taken = 0;
  int unsigned hold_left      = 0;
  int unsigned pattern_left   = 0;
  int unsigned stall_mode     = 0;
  int unsigned rx_cycle       = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        outputs_seen++;
        if (pending_outputs.size() == 0) begin
          $error("sample_out: unexpected output transaction, got %0d",
                 $signed(m_axis_tdata[SAMPLE_W-1:0]));
          mismatch_count++;
        end else begin
          logic [SAMPLE_W-1:0] want_y;
          want_y = pending_outputs.pop_front();
          if (m_axis_tdata[SAMPLE_W-1:0] !== want_y) begin
            $error("sample_out mismatch: expected %0d, got %0d",
                   $signed(want_y), $signed(m_axis_tdata[SAMPLE_W-1:0]));
            mismatch_count++;
          end
        end
      end
      rx_cycle++;
      if (pattern_left == 0) begin
        stall_mode   = $urandom_range(0, 3);
        pattern_left = $urandom_range(50, 300);
      end else begin
        pattern_left--;
      end
      if (hold_left == 0 && hold_off_asks != hold_off_taken) begin
        hold_left = LONG_HOLD;
        hold_off_taken++;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (stall_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ((rx_cycle % 7) < 2);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    coef_shadow = '{B0_RESET, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO};
    delay_one   = '0;
    delay_two   = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows, writes only once the section has drained
    for (int unsigned r = 0; r < NUM_ROWS; r++) begin
      if (stim_rows[r].kind == ROW_WRITE) begin
        if (!writes_open) wait_idle();
        write_reg(stim_rows[r].idx, stim_rows[r].value);
      end else begin
        close_writes();
        send_sample(stim_rows[r].value, stim_rows[r].typed, stim_rows[r].want);
      end
    end
    close_writes();

    // random phases, one coefficient setting each
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      apply_setting(phase_setting(p));
      if (p == NUM_PHASES - 1) begin
        // keep offering while the output side holds off
        no_gaps = 1'b1;
        hold_off_asks++;
      end
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        send_sample(rand_sample(), 1'b0, SMP_ZERO);
        if (p == NUM_PHASES - 1 && i == PHASE_ITEMS / 2) no_gaps = 1'b0;
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("tb_top: %0d samples in, %0d samples out, %0d coefficient settings plus table",
             samples_sent, outputs_seen, settings_used);
    $display("tb_top: %0d mismatches", mismatch_count);
    if (mismatch_count == 0 && pending_outputs.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // watchdog, far past the slowest legal run
  initial begin
    #2000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
